// ----- hdl/spg_pkg.sv -----
// Shared constants, codes and the cell store entry type for the gridding block.
`default_nettype none
package spg_pkg;
	// Grid geometry and radius limit.
	localparam int GRID_ROWS  = 64;
	localparam int GRID_COLS  = 64;
	localparam int MAX_RADIUS = 8;
	localparam int CELLS      = GRID_ROWS * GRID_COLS;
	localparam int ROW_W      = (GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1;
	localparam int COL_W      = (GRID_COLS > 1) ? $clog2(GRID_COLS) : 1;
	localparam int ADDR_W     = (CELLS > 1) ? $clog2(CELLS) : 1;
	localparam int RAD_MAX    = MAX_RADIUS * 256;

	// Field widths of one stored cell.
	localparam int WSUM_W = 48;
	localparam int WTS_W  = 32;
	localparam int CNT_W  = 16;

	// Command codes.
	localparam logic [1:0] CMD_ADD   = 2'd0;
	localparam logic [1:0] CMD_READ  = 2'd1;
	localparam logic [1:0] CMD_CLEAR = 2'd2;

	// Algorithm codes.
	localparam logic [1:0] ALG_CRESSMAN = 2'd0;
	localparam logic [1:0] ALG_BUCKET   = 2'd1;
	localparam logic [1:0] ALG_IDW      = 2'd2;
	localparam logic [1:0] ALG_NEAREST  = 2'd3;

	// Configuration register indexes.
	localparam logic [2:0] REG_ALGORITHM  = 3'd0;
	localparam logic [2:0] REG_RADIUS     = 3'd1;
	localparam logic [2:0] REG_POWER_HALF = 3'd2;
	localparam logic [2:0] REG_FILL       = 3'd3;
	localparam logic [2:0] REG_MIN_POINTS = 3'd4;

	// One cell of the store.
	typedef struct packed {
		logic signed [WSUM_W-1:0] wsum;
		logic [WTS_W-1:0]         wts;
		logic [CNT_W-1:0]         cnt;
	} entry_t;
endpackage
`default_nettype wire

// ----- hdl/spg_if.sv -----
// Handshake channel interfaces: sample/command words, result words and register writes.
`default_nettype none
interface spg_item_if;
	logic               valid;
	logic               ready;
	logic [1:0]         cmd;
	logic signed [19:0] col_pos;
	logic signed [19:0] row_pos;
	logic signed [31:0] sample_value;
	logic [5:0]         cell_row;
	logic [5:0]         cell_col;
	modport source (output valid, cmd, col_pos, row_pos, sample_value, cell_row, cell_col,
		input ready);
	modport sink (input valid, cmd, col_pos, row_pos, sample_value, cell_row, cell_col,
		output ready);
endinterface

interface spg_result_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] cell_value;
	logic [15:0]        cell_count;
	logic               cell_valid;
	modport source (output valid, cell_value, cell_count, cell_valid, input ready);
	modport sink (input valid, cell_value, cell_count, cell_valid, output ready);
endinterface

interface spg_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [31:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ----- hdl/spg_ram.sv -----
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none
module spg_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                             clk,
	input  wire logic                             we,
	input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                 wdata,
	input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// Write and registered read.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// ----- hdl/scattered_point_gridding.sv -----
// Scattered-point gridding engine: splats samples into a cell store and reads cells back.
// Add: per window cell address, distance, update (ADDR, D2, EVAL); a weighted cell then goes
//   through SQ (at power four only), the divider, multiply and accumulate, or straight to
//   multiply and accumulate when no division is needed; the window is up to 33x33 cells.
// Read: the cell is read, then divided out when needed, and put in the output register.
// Clear: a pass over all 4096 cells of the store, one cell per cycle; the same pass runs
//   after reset, during which no word is accepted. One word is worked on at a time.
`default_nettype none
module scattered_point_gridding (
	input  wire logic   clk,
	input  wire logic   arst_n,
	spg_item_if.sink    item,
	spg_result_if.source result,
	spg_cfg_if.sink     cfg
);
	localparam logic [3:0] ST_CLR  = 4'd0;
	localparam logic [3:0] ST_IDLE = 4'd1;
	localparam logic [3:0] ST_ADDR = 4'd2;
	localparam logic [3:0] ST_D2   = 4'd3;
	localparam logic [3:0] ST_EVAL = 4'd4;
	localparam logic [3:0] ST_SQ   = 4'd5;
	localparam logic [3:0] ST_DIV  = 4'd6;
	localparam logic [3:0] ST_MUL  = 4'd7;
	localparam logic [3:0] ST_ACC  = 4'd8;
	localparam logic [3:0] ST_RD   = 4'd9;
	localparam logic [3:0] ST_OUT  = 4'd10;

	localparam int AW = spg_pkg::ADDR_W;

	logic [3:0]  state_q;
	logic [AW-1:0] clr_addr_q;

	// Configuration registers.
	logic [1:0]         alg_q;
	logic [11:0]        rad_q;
	logic [1:0]         pwh_q;
	logic signed [31:0] fill_q;
	logic [15:0]        minp_q;

	// Per-word working registers.
	logic signed [31:0] sample_q;
	logic signed [19:0] cpos_q, rpos_q;
	logic [23:0]        r2_q;
	logic [spg_pkg::ROW_W-1:0] row_q, s1_q;
	logic [spg_pkg::COL_W-1:0] col_q, c0_q, c1_q;
	logic               oog_q;
	logic [42:0]        d2_q;
	logic signed [31:0] weight_q;
	logic signed [63:0] prod_q;

	// Divider registers.
	logic [63:0] dnum_q;
	logic [47:0] drem_q, dden_q;
	logic [6:0]  dcnt_q;
	logic        div_rd_q, neg_q;

	// Pending read result and output register.
	logic signed [31:0] res_value_q;
	logic [15:0]        res_cnt_q;
	logic               res_valid_q;
	logic               out_valid_q;
	logic signed [31:0] out_value_q;
	logic [15:0]        out_count_q;
	logic               out_cvalid_q;

	// Cell store.
	logic                ram_we;
	logic [AW-1:0]       ram_waddr, ram_raddr, cur_idx, in_idx;
	spg_pkg::entry_t     ram_wdata, ent;
	logic [$bits(spg_pkg::entry_t)-1:0] ram_rdata;

	spg_ram #(
		.WIDTH($bits(spg_pkg::entry_t)),
		.DEPTH(spg_pkg::CELLS)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign ent = spg_pkg::entry_t'(ram_rdata);

	// Cell addresses of the current window cell and of an incoming read.
	assign cur_idx = AW'(AW'(row_q) * AW'(spg_pkg::GRID_COLS)) + AW'(col_q);
	assign in_idx  = AW'(AW'(item.cell_row) * AW'(spg_pkg::GRID_COLS)) + AW'(item.cell_col);
	assign ram_raddr = (state_q == ST_IDLE) ? in_idx : cur_idx;
	assign ram_waddr = (state_q == ST_CLR) ? clr_addr_q : cur_idx;

	// Handshakes.
	assign item.ready        = (state_q == ST_IDLE);
	assign cfg.ready         = 1'b1;
	assign result.valid      = out_valid_q;
	assign result.cell_value = out_value_q;
	assign result.cell_count = out_count_q;
	assign result.cell_valid = out_cvalid_q;

	// Window set-up from an incoming sample.
	logic [15:0]        rad_ext;
	logic [11:0]        rq;
	logic [4:0]         win;
	logic signed [20:0] csum, rsum;
	logic signed [13:0] nc, nr, clo, chi, rlo, rhi;
	logic               win_skip;

	always_comb begin
		rad_ext  = 16'(rad_q);
		rq       = (rad_ext > 16'(spg_pkg::RAD_MAX)) ? 12'(spg_pkg::RAD_MAX) : rad_q;
		win      = rq[11:7];
		csum     = 21'(item.col_pos) + 21'sd128;
		rsum     = 21'(item.row_pos) + 21'sd128;
		nc       = 14'(csum >>> 8);
		nr       = 14'(rsum >>> 8);
		clo      = nc - $signed({9'd0, win});
		chi      = nc + $signed({9'd0, win});
		rlo      = nr - $signed({9'd0, win});
		rhi      = nr + $signed({9'd0, win});
		win_skip = (chi < 14'sd0) || (rhi < 14'sd0)
			|| (clo > 14'(spg_pkg::GRID_COLS - 1)) || (rlo > 14'(spg_pkg::GRID_ROWS - 1))
			|| (item.sample_value == fill_q);
	end

	// Squared distance from the sample to the current cell centre.
	logic signed [20:0] dx, dy;
	logic signed [41:0] dx2, dy2;
	logic [42:0]        d2;

	always_comb begin
		dx  = 21'(cpos_q) - $signed({7'd0, col_q, 8'd0});
		dy  = 21'(rpos_q) - $signed({7'd0, row_q, 8'd0});
		dx2 = dx * dx;
		dy2 = dy * dy;
		d2  = 43'($unsigned(dx2)) + 43'($unsigned(dy2));
	end

	// Divider step and quotient post-processing.
	logic [48:0] rem_sh;
	logic        rem_ge;
	logic [32:0] q_rd;
	logic signed [31:0] rd_value;
	logic signed [31:0] q_wt;

	always_comb begin
		rem_sh = {drem_q, dnum_q[63]};
		rem_ge = rem_sh >= {1'b0, dden_q};
		q_rd   = (dnum_q > 64'h8000_0000) ? 33'h0_8000_0000 : dnum_q[32:0];
		if (neg_q) begin
			rd_value = 32'(-$signed({1'b0, q_rd}));
		end else begin
			rd_value = (q_rd == 33'h0_8000_0000) ? 32'sh7FFF_FFFF : $signed(q_rd[31:0]);
		end
		q_wt = (dnum_q > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : $signed(dnum_q[31:0]);
	end

	// Read-side magnitudes for the normalizing division.
	logic [47:0] wsum_mag;
	logic [31:0] wts_mag;
	logic signed [31:0] wts_s;

	always_comb begin
		wts_s    = $signed(ent.wts);
		wsum_mag = ent.wsum[47] ? 48'(-ent.wsum) : ent.wsum[47:0];
		wts_mag  = wts_s[31] ? 32'(-wts_s) : ent.wts;
	end

	// Cell updates and store write data.
	logic signed [48:0] bsum, asum;
	logic signed [47:0] pshift;
	logic signed [32:0] wtsum;
	logic [15:0]        cnt_inc;
	spg_pkg::entry_t    upd;

	always_comb begin
		cnt_inc = (ent.cnt == 16'hFFFF) ? ent.cnt : ent.cnt + 16'd1;
		bsum    = 49'(ent.wsum) + 49'(sample_q);
		pshift  = 48'(prod_q >>> 16);
		asum    = 49'(ent.wsum) + 49'(pshift);
		wtsum   = 33'(wts_s) + 33'(weight_q);
		upd     = ent;
		ram_we  = 1'b0;
		ram_wdata = ent;
		unique case (state_q)
			ST_CLR: begin
				ram_we = 1'b1;
				ram_wdata.wsum = (alg_q == spg_pkg::ALG_NEAREST) ? 48'(fill_q) : '0;
				ram_wdata.wts  = (alg_q == spg_pkg::ALG_NEAREST) ? '1 : '0;
				ram_wdata.cnt  = '0;
			end
			ST_EVAL: begin
				if (alg_q == spg_pkg::ALG_BUCKET) begin
					ram_we = 1'b1;
					if (bsum > 49'sh0_7FFF_FFFF_FFFF) begin
						upd.wsum = 48'sh7FFF_FFFF_FFFF;
					end else if (bsum < -49'sh0_8000_0000_0000) begin
						upd.wsum = -48'sh8000_0000_0000;
					end else begin
						upd.wsum = bsum[47:0];
					end
					upd.cnt   = cnt_inc;
					ram_wdata = upd;
				end else if (alg_q == spg_pkg::ALG_NEAREST && d2_q <= 43'(r2_q)
						&& d2_q <= 43'(ent.wts)) begin
					ram_we    = 1'b1;
					upd.wts   = d2_q[31:0];
					upd.wsum  = 48'(sample_q);
					ram_wdata = upd;
				end
			end
			ST_ACC: begin
				ram_we = 1'b1;
				if (asum > 49'sh0_7FFF_FFFF_FFFF) begin
					upd.wsum = 48'sh7FFF_FFFF_FFFF;
				end else if (asum < -49'sh0_8000_0000_0000) begin
					upd.wsum = -48'sh8000_0000_0000;
				end else begin
					upd.wsum = asum[47:0];
				end
				if (wtsum > 33'sh0_7FFF_FFFF) begin
					upd.wts = 32'h7FFF_FFFF;
				end else if (wtsum < -33'sh0_8000_0000) begin
					upd.wts = 32'h8000_0000;
				end else begin
					upd.wts = wtsum[31:0];
				end
				upd.cnt   = cnt_inc;
				ram_wdata = upd;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alg_q  <= spg_pkg::ALG_CRESSMAN;
			rad_q  <= '0;
			pwh_q  <= 2'd1;
			fill_q <= '0;
			minp_q <= '0;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				spg_pkg::REG_ALGORITHM:  alg_q  <= cfg.data[1:0];
				spg_pkg::REG_RADIUS:     rad_q  <= cfg.data[11:0];
				spg_pkg::REG_POWER_HALF: pwh_q  <= cfg.data[1:0];
				spg_pkg::REG_FILL:       fill_q <= $signed(cfg.data);
				spg_pkg::REG_MIN_POINTS: minp_q <= cfg.data[15:0];
				default: begin
				end
			endcase
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_OUT && (!out_valid_q || result.ready)) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_OUT && (!out_valid_q || result.ready)) begin
			out_value_q  <= res_value_q;
			out_count_q  <= res_cnt_q;
			out_cvalid_q <= res_valid_q;
		end
	end

	// Sequencer: clearing pass, window walk, divider and read.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLR;
			clr_addr_q <= '0;
		end else begin
			unique case (state_q)
				ST_CLR: begin
					clr_addr_q <= clr_addr_q + AW'(1);
					if (clr_addr_q == AW'(spg_pkg::CELLS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (item.valid) begin
						clr_addr_q <= '0;
						priority if (item.cmd == spg_pkg::CMD_CLEAR) begin
							state_q <= ST_CLR;
						end else if (item.cmd == spg_pkg::CMD_READ) begin
							state_q <= ST_RD;
						end else if (item.cmd == spg_pkg::CMD_ADD && !win_skip) begin
							state_q <= ST_ADDR;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				ST_ADDR: state_q <= ST_D2;
				ST_D2:   state_q <= ST_EVAL;
				ST_EVAL: begin
					priority if (alg_q == spg_pkg::ALG_BUCKET || alg_q == spg_pkg::ALG_NEAREST
							|| d2_q > 43'(r2_q)) begin
						if (col_q == c1_q && row_q == s1_q) begin
							state_q <= ST_IDLE;
						end else begin
							state_q <= ST_ADDR;
						end
					end else if (alg_q == spg_pkg::ALG_CRESSMAN) begin
						state_q <= (d2_q == '0 && r2_q == '0) ? ST_MUL : ST_DIV;
					end else if (d2_q == '0) begin
						state_q <= ST_MUL;
					end else begin
						state_q <= pwh_q[1] ? ST_SQ : ST_DIV;
					end
				end
				ST_SQ: state_q <= ST_DIV;
				ST_DIV: begin
					if (dcnt_q == '0) begin
						state_q <= div_rd_q ? ST_OUT : ST_MUL;
					end
				end
				ST_MUL: state_q <= ST_ACC;
				ST_ACC: begin
					if (col_q == c1_q && row_q == s1_q) begin
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_ADDR;
					end
				end
				ST_RD: begin
					if (oog_q) begin
						state_q <= ST_OUT;
					end else begin
						unique case (alg_q)
							spg_pkg::ALG_CRESSMAN:
								state_q <= (wts_s != '0 && minp_q <= ent.cnt) ? ST_DIV : ST_OUT;
							spg_pkg::ALG_BUCKET:
								state_q <= (ent.cnt != '0) ? ST_DIV : ST_OUT;
							spg_pkg::ALG_IDW:
								state_q <= (wts_s != '0) ? ST_DIV : ST_OUT;
							default: state_q <= ST_OUT;
						endcase
					end
				end
				ST_OUT: begin
					if (!out_valid_q || result.ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers of the sequencer.
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				sample_q <= item.sample_value;
				cpos_q   <= item.col_pos;
				rpos_q   <= item.row_pos;
				r2_q     <= 24'(rq) * 24'(rq);
				oog_q    <= (11'(item.cell_row) >= 11'(spg_pkg::GRID_ROWS))
					|| (11'(item.cell_col) >= 11'(spg_pkg::GRID_COLS));
				if (item.cmd == spg_pkg::CMD_READ) begin
					row_q <= spg_pkg::ROW_W'(item.cell_row);
					col_q <= spg_pkg::COL_W'(item.cell_col);
				end else begin
					row_q <= (rlo < 14'sd0) ? '0 : spg_pkg::ROW_W'(rlo);
					col_q <= (clo < 14'sd0) ? '0 : spg_pkg::COL_W'(clo);
				end
				c0_q <= (clo < 14'sd0) ? '0 : spg_pkg::COL_W'(clo);
				c1_q <= (chi > 14'(spg_pkg::GRID_COLS - 1)) ? spg_pkg::COL_W'(spg_pkg::GRID_COLS - 1)
					: spg_pkg::COL_W'(chi);
				s1_q <= (rhi > 14'(spg_pkg::GRID_ROWS - 1)) ? spg_pkg::ROW_W'(spg_pkg::GRID_ROWS - 1)
					: spg_pkg::ROW_W'(rhi);
			end
			ST_D2: d2_q <= d2;
			ST_EVAL: begin
				div_rd_q <= 1'b0;
				dcnt_q   <= 7'd64;
				drem_q   <= '0;
				weight_q <= (alg_q == spg_pkg::ALG_IDW) ? fill_q : '0;
				if (alg_q == spg_pkg::ALG_CRESSMAN) begin
					dnum_q <= 64'(r2_q - d2_q[23:0]) << 16;
					dden_q <= 48'(r2_q) + 48'(d2_q[23:0]);
				end else begin
					dnum_q <= 64'h1 << 32;
					dden_q <= 48'(d2_q[23:0]);
				end
				if (alg_q == spg_pkg::ALG_BUCKET || alg_q == spg_pkg::ALG_NEAREST
						|| d2_q > 43'(r2_q)) begin
					if (col_q == c1_q) begin
						col_q <= c0_q;
						row_q <= row_q + spg_pkg::ROW_W'(1);
					end else begin
						col_q <= col_q + spg_pkg::COL_W'(1);
					end
				end
			end
			ST_SQ: begin
				dnum_q <= 64'h1 << 48;
				dden_q <= d2_q[23:0] * d2_q[23:0];
			end
			ST_DIV: begin
				if (dcnt_q != '0) begin
					drem_q <= rem_ge ? 48'(rem_sh - {1'b0, dden_q}) : rem_sh[47:0];
					dnum_q <= {dnum_q[62:0], rem_ge};
					dcnt_q <= dcnt_q - 7'd1;
				end else begin
					weight_q    <= q_wt;
					res_value_q <= rd_value;
					res_valid_q <= 1'b1;
				end
			end
			ST_MUL: prod_q <= sample_q * weight_q;
			ST_ACC: begin
				if (col_q == c1_q) begin
					col_q <= c0_q;
					row_q <= row_q + spg_pkg::ROW_W'(1);
				end else begin
					col_q <= col_q + spg_pkg::COL_W'(1);
				end
			end
			ST_RD: begin
				div_rd_q    <= 1'b1;
				dcnt_q      <= 7'd64;
				drem_q      <= '0;
				res_value_q <= fill_q;
				res_valid_q <= 1'b0;
				res_cnt_q   <= oog_q ? '0 : ent.cnt;
				neg_q       <= ent.wsum[47] ^ (alg_q != spg_pkg::ALG_BUCKET && wts_s[31]);
				if (alg_q == spg_pkg::ALG_BUCKET) begin
					dnum_q <= 64'(wsum_mag);
					dden_q <= 48'(ent.cnt);
				end else begin
					dnum_q <= {wsum_mag, 16'd0};
					dden_q <= 48'(wts_mag);
				end
				if (!oog_q && alg_q == spg_pkg::ALG_NEAREST && ent.wts != '1) begin
					res_value_q <= $signed(ent.wsum[31:0]);
					res_valid_q <= 1'b1;
				end
			end
			default: begin
			end
		endcase
	end
endmodule
`default_nettype wire
